### hw/rtl/tiny_accumulator_cpu_step_core_defines.svh
// Assertion macros shared by the checker of the tiny accumulator CPU step core.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef TINY_ACCUMULATOR_CPU_STEP_CORE_DEFINES_SVH
`define TINY_ACCUMULATOR_CPU_STEP_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define TACS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tacs: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define TACS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tacs: next-cycle check failed");

`endif

### hw/rtl/tacs_pkg.sv
// Shared types and constants of the tiny accumulator CPU step core.
// Used by the front end, the op queue, the execution back end and the checker.
`default_nettype none

package tacs_pkg;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int DIV_STEPS = 8;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [5:0] CLS_IN  = 6'h30;
    localparam logic [5:0] CLS_OUT = 6'h31;
    localparam logic [1:0] REG_D   = 2'd3;

    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_DIV = 2'd3;

    typedef enum logic [2:0] {
        OP_MOVI,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_IN,
        OP_OUT,
        OP_ILL
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ILLEGAL,
        ST_DIVZERO,
        ST_HALTED
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_OPER,
        BK_DIV,
        BK_WB
    } bk_state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] dst;
        logic [1:0] src;
        logic [7:0] imm;
    } uop_t;

    typedef struct packed {
        logic valid;
        uop_t uop;
    } q_wr_t;

    typedef struct packed {
        logic empty;
        uop_t uop;
    } q_rd_t;

endpackage

`default_nettype wire

### hw/rtl/tacs_front.sv
// Front end: accepts instruction bytes and decodes them into micro-ops.
// Depends on tacs_pkg; feeds tacs_queue.
`default_nettype none

module tacs_front
    import tacs_pkg::*;
(
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic [7:0] instr_byte,
    input  wire logic [7:0] in_value,
    output q_wr_t           q_wr
);

    uop_t uop;

    always_comb
    begin
        uop.op  = OP_ILL;
        uop.dst = instr_byte[3:2];
        uop.src = instr_byte[1:0];
        uop.imm = in_value;
        if (!instr_byte[7])
        begin
            uop.op  = OP_MOVI;
            uop.dst = REG_D;
            uop.imm = {1'b0, instr_byte[6:0]};
        end
        else if (instr_byte[6])
        begin
            if (instr_byte[7:2] == CLS_IN)
            begin
                uop.op  = OP_IN;
                uop.dst = instr_byte[1:0];
            end
            else if (instr_byte[7:2] == CLS_OUT)
            begin
                uop.op = OP_OUT;
            end
            else
            begin
                uop.op = OP_ILL;
            end
        end
        else
        begin
            case (instr_byte[5:4])
                ALU_ADD: uop.op = OP_ADD;
                ALU_SUB: uop.op = OP_SUB;
                ALU_MUL: uop.op = OP_MUL;
                default: uop.op = OP_DIV;
            endcase
        end
    end

    assign q_wr.valid = push && !full;
    assign q_wr.uop   = uop;

endmodule

`default_nettype wire

### hw/rtl/tacs_queue.sv
// Short queue of decoded micro-ops between the front end and the back end.
// Depends on tacs_pkg.
`default_nettype none

module tacs_queue
    import tacs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire q_wr_t q_wr,
    input  wire logic  q_pop,
    output logic       full,
    output q_rd_t      q_rd
);

    uop_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_pop;

    assign full   = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_rd.empty = (cnt_reg == '0);
    assign q_rd.uop   = mem_reg[rd_ptr_reg];
    assign do_pop     = q_pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_wr.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_wr.valid && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !q_wr.valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.valid)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.uop;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tacs_back.sv
// Back end: register file, ALU, radix-2 divider, halt flag and result register.
// Depends on tacs_pkg; takes micro-ops from tacs_queue.
`default_nettype none

module tacs_back
    import tacs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire q_rd_t      q_rd,
    output logic            q_pop,
    input  wire logic       pop,
    output logic            empty,
    output logic            out_valid,
    output logic [7:0]      out_value,
    output logic [1:0]      status
);

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic              oper;
    logic              div_step;
    logic              wb;
    logic              go_div;
    logic              div_last;

    logic [7:0]        rf_mem [4];
    logic [3:0]        rf_vld_reg;
    logic [7:0]        a_raw_reg;
    logic [7:0]        b_raw_reg;
    logic              a_hit_reg;
    logic              b_hit_reg;
    logic [7:0]        op_a;
    logic [7:0]        op_b;
    uop_t              uop_reg;

    logic              halted_reg;
    logic              halted_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic [7:0]        val_reg;
    logic [7:0]        val_next;
    logic [7:0]        rem_reg;
    logic [7:0]        rem_next;
    logic              wr_reg;
    logic              wr_next;
    status_t           st_reg;
    status_t           st_next;
    logic              ov_reg;
    logic              ov_next;
    logic [7:0]        oval_reg;
    logic [7:0]        oval_next;

    logic              res_valid_reg;
    logic              res_valid_next;
    status_t           res_st_reg;
    logic              res_ov_reg;
    logic [7:0]        res_val_reg;

    logic [8:0]        trial;
    logic              ge;
    logic [7:0]        prod;

    assign op_a     = a_hit_reg ? a_raw_reg : '0;
    assign op_b     = b_hit_reg ? b_raw_reg : '0;
    assign go_div   = !halted_reg && (uop_reg.op == OP_DIV) && (op_b != '0);
    assign div_last = (cnt_reg == DCNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_rd.empty)
                begin
                    state_next = BK_OPER;
                end
            end
            BK_OPER:
            begin
                state_next = go_div ? BK_DIV : BK_WB;
            end
            BK_DIV:
            begin
                if (div_last)
                begin
                    state_next = BK_WB;
                end
            end
            BK_WB:
            begin
                if (!res_valid_reg || pop)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        oper     = 1'b0;
        div_step = 1'b0;
        wb       = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop    = !q_rd.empty;
            BK_OPER: oper     = 1'b1;
            BK_DIV:  div_step = 1'b1;
            BK_WB:   wb       = !res_valid_reg || pop;
            default: q_pop    = 1'b0;
        endcase
    end

    assign trial = {rem_reg, val_reg[7]};
    assign ge    = (trial >= {1'b0, op_b});
    assign prod  = op_a * op_b;

    always_comb
    begin
        halted_next = halted_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        rem_next    = rem_reg;
        wr_next     = wr_reg;
        st_next     = st_reg;
        ov_next     = ov_reg;
        oval_next   = oval_reg;
        if (oper)
        begin
            wr_next   = 1'b0;
            st_next   = ST_OK;
            ov_next   = 1'b0;
            oval_next = '0;
            val_next  = '0;
            rem_next  = '0;
            cnt_next  = '0;
            if (halted_reg)
            begin
                st_next = ST_HALTED;
            end
            else
            begin
                case (uop_reg.op)
                    OP_MOVI, OP_IN:
                    begin
                        val_next = uop_reg.imm;
                        wr_next  = 1'b1;
                    end
                    OP_ADD:
                    begin
                        val_next = op_a + op_b;
                        wr_next  = 1'b1;
                    end
                    OP_SUB:
                    begin
                        val_next = op_a - op_b;
                        wr_next  = 1'b1;
                    end
                    OP_MUL:
                    begin
                        val_next = prod;
                        wr_next  = 1'b1;
                    end
                    OP_DIV:
                    begin
                        if (op_b == '0)
                        begin
                            st_next     = ST_DIVZERO;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            val_next = op_a;
                            wr_next  = 1'b1;
                        end
                    end
                    OP_OUT:
                    begin
                        ov_next   = 1'b1;
                        oval_next = op_b;
                    end
                    default:
                    begin
                        st_next     = ST_ILLEGAL;
                        halted_next = 1'b1;
                    end
                endcase
            end
        end
        else if (div_step)
        begin
            rem_next = ge ? 8'(trial - {1'b0, op_b}) : trial[7:0];
            val_next = {val_reg[6:0], ge};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (wb)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            halted_reg    <= 1'b0;
            cnt_reg       <= '0;
            wr_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            rf_vld_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            halted_reg    <= halted_next;
            cnt_reg       <= cnt_next;
            wr_reg        <= wr_next;
            res_valid_reg <= res_valid_next;
            if (wb && wr_reg)
            begin
                rf_vld_reg[uop_reg.dst] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            uop_reg   <= q_rd.uop;
            a_raw_reg <= rf_mem[q_rd.uop.dst];
            b_raw_reg <= rf_mem[q_rd.uop.src];
            a_hit_reg <= rf_vld_reg[q_rd.uop.dst];
            b_hit_reg <= rf_vld_reg[q_rd.uop.src];
        end
        if (wb && wr_reg)
        begin
            rf_mem[uop_reg.dst] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        st_reg   <= st_next;
        ov_reg   <= ov_next;
        oval_reg <= oval_next;
        if (wb)
        begin
            res_st_reg  <= st_reg;
            res_ov_reg  <= ov_reg;
            res_val_reg <= oval_reg;
        end
    end

    assign empty     = !res_valid_reg;
    assign out_valid = res_ov_reg;
    assign out_value = res_val_reg;
    assign status    = res_st_reg;

endmodule

`default_nettype wire

### hw/rtl/tiny_accumulator_cpu_step_core.sv
// Tiny accumulator CPU step core: one instruction byte in, one result out.
// The back end takes one instruction at a time and accepts the next only after
// the last result is written back; a divide runs the eight radix-2 steps of the
// subtract unit in the back end, and write-back waits while an unpopped result is held.
// Reset (rst_n low, asynchronous) empties the op queue and the result register,
// makes registers A-D read as zero and clears the halt flag.
`default_nettype none

module tiny_accumulator_cpu_step_core
    import tacs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] instr_byte,
    input  wire logic [7:0] in_value,
    input  wire logic       pop,
    output logic            empty,
    output logic            out_valid,
    output logic [7:0]      out_value,
    output logic [1:0]      status
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_pop;

    tacs_front u_front (
        .push       (push),
        .full       (full),
        .instr_byte (instr_byte),
        .in_value   (in_value),
        .q_wr       (q_wr)
    );

    tacs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .q_pop (q_pop),
        .full  (full),
        .q_rd  (q_rd)
    );

    tacs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_valid (out_valid),
        .out_value (out_value),
        .status    (status)
    );

endmodule

`default_nettype wire

### hw/rtl/tacs_checker.sv
// Port-level checker of the tiny accumulator CPU step core and its bind.
// Depends on tacs_pkg and tiny_accumulator_cpu_step_core_defines.svh.
`default_nettype none

`include "tiny_accumulator_cpu_step_core_defines.svh"

module tacs_checker
    import tacs_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pop,
    input wire logic       empty,
    input wire logic       out_valid,
    input wire logic [7:0] out_value,
    input wire logic [1:0] status
);

    logic halt_seen_reg;
    logic halt_seen_next;
    logic take;

    assign take = pop && !empty;

    always_comb
    begin
        halt_seen_next = halt_seen_reg;
        if (take && ((status == ST_ILLEGAL) || (status == ST_DIVZERO)))
        begin
            halt_seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
        end
        else
        begin
            halt_seen_reg <= halt_seen_next;
        end
    end

    `TACS_ASSERT_NOW(a_out_ok, !empty && out_valid, status == ST_OK)
    `TACS_ASSERT_NOW(a_no_out_zero, !empty && !out_valid, out_value == 8'd0)
    `TACS_ASSERT_NOW(a_halt_sticky, !empty && halt_seen_reg, status == ST_HALTED)
    `TACS_ASSERT_NOW(a_halt_cause, !empty && !halt_seen_reg, status != ST_HALTED)
    `TACS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status))

endmodule

bind tiny_accumulator_cpu_step_core tacs_checker u_checker (.*);

`default_nettype wire
